// File: design/bb_pkg.sv
// Shared types and constants of the 3x3 box blur.
`timescale 1ns / 1ps
package bb_pkg;

    localparam int COL_W      = 13;
    localparam int EXT_W      = 14;
    localparam int ROW_W      = 12;
    localparam int WID_W      = 12;
    localparam int HGT_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int SUM_W      = 12;
    localparam int CNT_W      = 4;
    localparam int NUM_W      = 13;
    localparam int MAX_HEIGHT = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } t_op;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        t_op        operation;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } t_in_request;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       last_of_run;
        logic       end_of_frame;
    } t_result;

    typedef struct packed {
        t_op              op;
        logic [COL_W-1:0] col;
        logic [1:0]       span;
        logic             two_rows;
        logic             emit_a;
        logic             emit_b;
        logic             a_wide;
        logic             b_wide;
        logic             eof;
        t_pixel           px;
    } t_cmd;

    typedef struct packed {
        logic [SUM_W-1:0] sum_red;
        logic [SUM_W-1:0] sum_green;
        logic [SUM_W-1:0] sum_blue;
        logic [CNT_W-1:0] count;
    } t_div_req;

    typedef enum logic [2:0] {
        B_IDLE,
        B_READ,
        B_SUM_A,
        B_SUM_B,
        B_DRAIN,
        B_SUM_D,
        B_DIV_WAIT
    } t_back_state;

endpackage

// File: design/box_blur_3x3.sv
// Top level of the streaming 3x3 box blur on RGB pixels.
// Pixels arrive in raster order; each pixel's result is the per-channel mean of its in-frame
// 3x3 neighbors, rounded half up, and is delivered once the pixel below-right of it has
// arrived, while the frame's last row is delivered by drain requests, one result each.
// The front part tracks the frame position and queues commands; the back part owns the two
// line buffers and the window. The back part takes one command at a time: a pixel updates the
// line buffers and window and then runs the divider once for each result it causes, and a drain
// sums up to three buffered columns before its single division. The two-stage reciprocal divider
// is shared by the three channels, and a full two-entry result queue holds the back part back.
// The line buffers need no clearing after reset.
`timescale 1ns / 1ps
module box_blur_3x3 import bb_pkg::*; #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  t_in_request           i_request,
    output logic                  o_full,
    output logic                  o_empty,
    input  logic                  i_pop,
    output t_result               o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic cmd_push;
    t_cmd cmd_in;
    logic cmd_full;
    logic cmd_valid;
    t_cmd cmd_out;
    logic cmd_pop;

    bb_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_request   (i_request),
        .o_full      (o_full),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in),
        .i_cmd_full  (cmd_full)
    );

    bb_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (cmd_full),
        .o_valid (cmd_valid),
        .o_cmd   (cmd_out),
        .i_pop   (cmd_pop)
    );

    bb_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_result    (o_result)
    );

endmodule

// File: design/bb_cmd_q.sv
// Two-entry command queue between the front and back parts of the box blur.
`timescale 1ns / 1ps
module bb_cmd_q import bb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd       r_mem [2];
    logic       r_rd;
    logic       r_wr;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) begin
                r_wr <= !r_wr;
            end
            if (i_pop && o_valid) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push && !o_full) - 2'(i_pop && o_valid);
        end
    end

endmodule

// File: design/bb_front.sv
// Front part of the box blur: frame position, configuration and command classification.
`timescale 1ns / 1ps
module bb_front import bb_pkg::*; #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  t_in_request           i_request,
    output logic                  o_full,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_cmd_push,
    output t_cmd                  o_cmd,
    input  logic                  i_cmd_full
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic [WID_W-1:0] r_width;
    logic [HGT_W-1:0] r_height;
    logic [AW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [AW-1:0]    r_drain_col;
    logic             r_draining;

    logic [EXT_W-1:0] w_x;
    logic [HGT_W-1:0] h_x;
    logic             last_col;
    logic             last_row;
    logic             d_last;
    logic             accept;
    logic             is_pix;

    always_comb begin
        if (r_width == '0) begin
            w_x = EXT_W'(1);
        end else if (EXT_W'(r_width) > EXT_W'(MAX_WIDTH)) begin
            w_x = EXT_W'(MAX_WIDTH);
        end else begin
            w_x = EXT_W'(r_width);
        end
        if (r_height == '0) begin
            h_x = HGT_W'(1);
        end else if (r_height > HGT_W'(MAX_HEIGHT)) begin
            h_x = HGT_W'(MAX_HEIGHT);
        end else begin
            h_x = r_height;
        end
    end

    assign last_col    = (EXT_W'(r_col) + EXT_W'(1)) >= w_x;
    assign last_row    = (HGT_W'(r_row) + HGT_W'(1)) >= h_x;
    assign d_last      = (EXT_W'(r_drain_col) + EXT_W'(1)) >= w_x;
    assign o_full      = i_cmd_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_push && !o_full;
    assign is_pix      = (i_request.operation == OP_PIXEL);
    assign o_cmd_push  = accept && (is_pix ? !r_draining : r_draining);

    always_comb begin
        o_cmd          = '0;
        o_cmd.op       = i_request.operation;
        o_cmd.px.red   = i_request.in_red;
        o_cmd.px.green = i_request.in_green;
        o_cmd.px.blue  = i_request.in_blue;
        if (is_pix) begin
            o_cmd.col      = COL_W'(r_col);
            o_cmd.two_rows = (r_row >= ROW_W'(2));
            o_cmd.emit_a   = (r_row != '0) && (r_col != '0);
            o_cmd.emit_b   = (r_row != '0) && last_col;
            o_cmd.a_wide   = (EXT_W'(r_col) >= EXT_W'(2));
            o_cmd.b_wide   = (r_col != '0);
        end else begin
            o_cmd.col      = (r_drain_col == '0) ? '0 : COL_W'(r_drain_col - AW'(1));
            o_cmd.span     = 2'd1 + 2'(r_drain_col != '0) + 2'(!d_last);
            o_cmd.two_rows = (h_x >= HGT_W'(2));
            o_cmd.eof      = d_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= WID_W'(640);
            r_height    <= HGT_W'(480);
            r_col       <= '0;
            r_row       <= '0;
            r_drain_col <= '0;
            r_draining  <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_WIDTH: begin
                    r_width     <= i_cfg_data[WID_W-1:0];
                    r_col       <= '0;
                    r_row       <= '0;
                    r_drain_col <= '0;
                    r_draining  <= 1'b0;
                end
                REG_HEIGHT: begin
                    r_height    <= i_cfg_data;
                    r_col       <= '0;
                    r_row       <= '0;
                    r_drain_col <= '0;
                    r_draining  <= 1'b0;
                end
                default: begin
                end
            endcase
        end else if (o_cmd_push) begin
            if (is_pix) begin
                if (last_col) begin
                    r_col <= '0;
                    if (last_row) begin
                        r_row       <= '0;
                        r_draining  <= 1'b1;
                        r_drain_col <= '0;
                    end else begin
                        r_row <= r_row + ROW_W'(1);
                    end
                end else begin
                    r_col <= r_col + AW'(1);
                end
            end else begin
                if (d_last) begin
                    r_draining  <= 1'b0;
                    r_drain_col <= '0;
                end else begin
                    r_drain_col <= r_drain_col + AW'(1);
                end
            end
        end
    end

endmodule

// File: design/bb_div.sv
// Rounding divider for the three channel sums by reciprocal multiplication.
`timescale 1ns / 1ps
module bb_div import bb_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_div_req i_req,
    output logic     o_done,
    output t_pixel   o_quot
);

    localparam int SHIFT  = 17;
    localparam int RCP_W  = 17;
    localparam int PROD_W = NUM_W + RCP_W;

    // Reciprocal of twice the count scaled by 2^17 and rounded up; exact for numerators below 2^13.
    function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RCP_W-1:0] m;
        unique case (n)
            4'd1:    m = 17'd65536;
            4'd2:    m = 17'd32768;
            4'd3:    m = 17'd21846;
            4'd4:    m = 17'd16384;
            4'd5:    m = 17'd13108;
            4'd6:    m = 17'd10923;
            4'd7:    m = 17'd9363;
            4'd8:    m = 17'd8192;
            4'd9:    m = 17'd7282;
            default: m = 17'd65536;
        endcase
        return m;
    endfunction

    logic [2:0][NUM_W-1:0]  r_num;
    logic [RCP_W-1:0]       r_rcp;
    logic [2:0][7:0]        r_q;
    logic                   r_busy;
    logic                   r_done;

    logic [2:0][PROD_W-1:0] prod;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            prod[k] = PROD_W'(r_num[k]) * PROD_W'(r_rcp);
        end
    end

    assign o_done       = r_done;
    assign o_quot.red   = r_q[0];
    assign o_quot.green = r_q[1];
    assign o_quot.blue  = r_q[2];

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num[0] <= NUM_W'({i_req.sum_red, 1'b0}) + NUM_W'(i_req.count);
            r_num[1] <= NUM_W'({i_req.sum_green, 1'b0}) + NUM_W'(i_req.count);
            r_num[2] <= NUM_W'({i_req.sum_blue, 1'b0}) + NUM_W'(i_req.count);
            r_rcp    <= recip(i_req.count);
        end
        if (r_busy) begin
            for (int k = 0; k < 3; k++) begin
                r_q[k] <= prod[k][SHIFT +: 8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a run");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held longer than one cycle");

endmodule

// File: design/bb_back.sv
// Back part of the box blur: line buffers, window, sums, divider and result queue.
`timescale 1ns / 1ps
module bb_back import bb_pkg::*; #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    output logic    o_empty,
    input  logic    i_pop,
    output t_result o_result
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    function automatic t_div_req win_sum(input t_pixel [2:0][2:0] win,
                                         input logic all_rows,
                                         input logic [1:0] first_col);
        t_div_req s;
        s = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if ((i != 0 || all_rows) && 2'(j) >= first_col) begin
                    s.sum_red   = s.sum_red + SUM_W'(win[i][j].red);
                    s.sum_green = s.sum_green + SUM_W'(win[i][j].green);
                    s.sum_blue  = s.sum_blue + SUM_W'(win[i][j].blue);
                    s.count     = s.count + CNT_W'(1);
                end
            end
        end
        return s;
    endfunction

    t_pixel r_upper_mem [MAX_WIDTH];
    t_pixel r_middle_mem [MAX_WIDTH];
    t_pixel r_rd_upper;
    t_pixel r_rd_middle;

    t_back_state        r_state;
    t_back_state        n_state;
    t_cmd               r_cmd;
    t_pixel [2:0][2:0]  r_win;
    logic [AW-1:0]      r_rd_col;
    logic [1:0]         r_left;
    t_div_req           r_acc;
    logic               r_pend_b;
    logic               r_last;
    logic               r_eof;
    t_result            r_out [2];
    logic               r_out_rd;
    logic               r_out_wr;
    logic [1:0]         r_out_cnt;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic               div_start;
    t_div_req           div_req;
    logic               div_done;
    t_pixel             div_quot;
    logic               room;
    logic               out_push;
    logic               out_pop;

    assign room     = (r_out_cnt != 2'd2);
    assign o_empty  = (r_out_cnt == 2'd0);
    assign out_pop  = i_pop && !o_empty;
    assign o_result = r_out[r_out_rd];
    assign wr_en    = (r_state == B_READ);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = (i_cmd.op == OP_PIXEL) ? B_READ : B_DRAIN;
                end
            end
            B_READ: begin
                if (r_cmd.emit_a) begin
                    n_state = B_SUM_A;
                end else if (r_cmd.emit_b) begin
                    n_state = B_SUM_B;
                end else begin
                    n_state = B_IDLE;
                end
            end
            B_SUM_A, B_SUM_B, B_SUM_D: begin
                if (room) begin
                    n_state = B_DIV_WAIT;
                end
            end
            B_DRAIN: begin
                if (r_left == 2'd0) begin
                    n_state = B_SUM_D;
                end
            end
            B_DIV_WAIT: begin
                if (div_done) begin
                    n_state = r_pend_b ? B_SUM_B : B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = r_rd_col;
        div_start = 1'b0;
        div_req   = r_acc;
        out_push  = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                o_cmd_pop = i_cmd_valid;
                rd_en     = i_cmd_valid;
                rd_addr   = i_cmd.col[AW-1:0];
            end
            B_SUM_A: begin
                div_start = room;
                div_req   = win_sum(r_win, r_cmd.two_rows, r_cmd.a_wide ? 2'd0 : 2'd1);
            end
            B_SUM_B: begin
                div_start = room;
                div_req   = win_sum(r_win, r_cmd.two_rows, r_cmd.b_wide ? 2'd1 : 2'd2);
            end
            B_SUM_D: begin
                div_start = room;
            end
            B_DRAIN: begin
                rd_en = (r_left != 2'd0);
            end
            B_DIV_WAIT: begin
                out_push = div_done;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_upper  <= r_upper_mem[rd_addr];
            r_rd_middle <= r_middle_mem[rd_addr];
        end
        if (wr_en) begin
            r_upper_mem[r_cmd.col[AW-1:0]]  <= r_rd_middle;
            r_middle_mem[r_cmd.col[AW-1:0]] <= r_cmd.px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd    <= i_cmd;
            r_rd_col <= i_cmd.col[AW-1:0] + AW'(1);
            r_left   <= i_cmd.span - 2'd1;
            r_acc    <= '0;
        end else if (r_state == B_DRAIN) begin
            r_acc.sum_red   <= r_acc.sum_red + SUM_W'(r_rd_middle.red)
                             + (r_cmd.two_rows ? SUM_W'(r_rd_upper.red) : '0);
            r_acc.sum_green <= r_acc.sum_green + SUM_W'(r_rd_middle.green)
                             + (r_cmd.two_rows ? SUM_W'(r_rd_upper.green) : '0);
            r_acc.sum_blue  <= r_acc.sum_blue + SUM_W'(r_rd_middle.blue)
                             + (r_cmd.two_rows ? SUM_W'(r_rd_upper.blue) : '0);
            r_acc.count     <= r_acc.count + (r_cmd.two_rows ? CNT_W'(2) : CNT_W'(1));
            if (r_left != 2'd0) begin
                r_rd_col <= r_rd_col + AW'(1);
                r_left   <= r_left - 2'd1;
            end
        end
        if (div_start) begin
            r_pend_b <= (r_state == B_SUM_A) && r_cmd.emit_b;
            r_last   <= !((r_state == B_SUM_A) && r_cmd.emit_b);
            r_eof    <= (r_state == B_SUM_D) && r_cmd.eof;
        end
        if (out_push) begin
            r_out[r_out_wr] <= '{out_red: div_quot.red, out_green: div_quot.green,
                                 out_blue: div_quot.blue, last_of_run: r_last,
                                 end_of_frame: r_eof};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_win     <= '0;
            r_out_rd  <= 1'b0;
            r_out_wr  <= 1'b0;
            r_out_cnt <= 2'd0;
        end else begin
            r_state <= n_state;
            if (wr_en) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[k][0] <= r_win[k][1];
                    r_win[k][1] <= r_win[k][2];
                end
                r_win[0][2] <= r_rd_upper;
                r_win[1][2] <= r_rd_middle;
                r_win[2][2] <= r_cmd.px;
            end
            if (out_push) begin
                r_out_wr <= !r_out_wr;
            end
            if (out_pop) begin
                r_out_rd <= !r_out_rd;
            end
            r_out_cnt <= r_out_cnt + 2'(out_push) - 2'(out_pop);
        end
    end

    bb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    a_out_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_cnt != 2'd3)
        else $error("result queue overflow");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == B_DIV_WAIT)
        else $error("divider result arrived outside the wait state");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_push && !out_pop) |-> r_out_cnt != 2'd2)
        else $error("result pushed into a full queue");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> r_state == B_IDLE)
        else $error("command taken while busy");

endmodule
